/* design/hds_pkg.sv */
package hds_pkg;

  localparam int GRID_SIZE = 128;
  localparam int IDX_W     = $clog2(GRID_SIZE);
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int TEMP_W    = 24;
  localparam int ALPHA_W   = 15;
  localparam int STEPS_W   = 16;
  localparam int COORD_W   = 7;
  localparam int FRAC_W    = 16;
  localparam int N_TAPS    = 5;
  localparam int TAP_W     = $clog2(N_TAPS + 2);

  localparam logic [ADDR_W-1:0]  LAST_CELL = '1;
  localparam logic [TEMP_W-1:0]  TEMP_MAX  = '1;
  localparam logic [STEPS_W-1:0] STEPS_RST = 16'd100;
  localparam logic [ALPHA_W-1:0] ALPHA_RST = 15'd6554;
  localparam logic [TEMP_W-1:0]  SRC_RST   = 24'd6553600;

  // Heat source rectangles, half-open row and column ranges
  localparam int N_SRC = 3;
  localparam int SRC_R0 [N_SRC] = '{15, 65, 35};
  localparam int SRC_R1 [N_SRC] = '{25, 75, 55};
  localparam int SRC_C0 [N_SRC] = '{15, 65, 75};
  localparam int SRC_C1 [N_SRC] = '{25, 75, 85};

  // Stencil taps in read order
  localparam int TAP_C = 0;
  localparam int TAP_N = 1;
  localparam int TAP_S = 2;
  localparam int TAP_W_ = 3;
  localparam int TAP_E = 4;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_RUN   = 2'd1,
    ACT_READ  = 2'd2
  } action_e;

  typedef enum logic {
    KIND_RUN  = 1'b0,
    KIND_READ = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    CFG_STEPS = 2'd0,
    CFG_ALPHA = 2'd1,
    CFG_SRC   = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FORCE,
    S_RD,
    S_ALU,
    S_WR,
    S_MM,
    S_MMT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]         action;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [TEMP_W-1:0]  cell_value;
  } cmd_t;

  typedef struct packed {
    logic              kind;
    logic [TEMP_W-1:0] out_value;
    logic [TEMP_W-1:0] min_value;
    logic [TEMP_W-1:0] max_value;
  } res_t;

  typedef struct packed {
    logic              we;
    logic              wbank;
    logic [ADDR_W-1:0] waddr;
    logic [TEMP_W-1:0] wdata;
    logic              re;
    logic              rbank;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  function automatic logic is_source(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < N_SRC; k++) begin
      if (int'(r) >= SRC_R0[k] && int'(r) < SRC_R1[k] &&
          int'(c) >= SRC_C0[k] && int'(c) < SRC_C1[k]) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

/* design/heat_diffusion_stencil_engine_unit.sv */
// Heat diffusion engine on a 128 x 128 grid of unsigned Q8.16 temperatures.
// After reset the block clears the grid with busy high; no item is taken
// then, configuration writes are. A read item's result comes through the read
// register of the grid memory and then the result register; reads may follow
// back to back. A run item keeps busy high through a sweep of source forcing,
// then per step one sweep of every cell in which each cell reads its five
// stencil taps one at a time from the single read port of the grid memory
// (interior cells then wait for the stencil unit), then a min/max sweep, after
// which the run result strobes once. Results appear for exactly one cycle on
// res_valid_o and cannot be held off by the receiver.
module heat_diffusion_stencil_engine_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  hds_pkg::cmd_t                 cmd_i,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [hds_pkg::TEMP_W-1:0]    cfg_wdata_i,
  output logic                          res_valid_o,
  output hds_pkg::res_t                 res_o
);
  import hds_pkg::*;

  state_e state_q, state_d;

  logic [STEPS_W-1:0] steps_cfg_q;
  logic [ALPHA_W-1:0] alpha_cfg_q;
  logic [TEMP_W-1:0]  src_cfg_q;

  logic               sel_q;        // bank holding the current grid
  logic [ADDR_W-1:0]  cell_q;
  logic [STEPS_W-1:0] step_q;
  logic [TAP_W-1:0]   tap_idx_q;
  logic [TEMP_W-1:0]  tap_q [N_TAPS];
  logic               rd_pend_q;
  logic               mm_vld_q, mm_first_q;
  logic [TEMP_W-1:0]  min_q, max_q;
  logic               res_valid_q;
  res_t               res_q;

  mem_req_t           mem_req;
  logic [TEMP_W-1:0]  rdata;
  logic               alu_start, alu_done;
  logic [TEMP_W-1:0]  alu_res;

  logic               accept;
  logic [ADDR_W-1:0]  host_addr;
  logic [IDX_W-1:0]   cur_row, cur_col;
  logic               cur_src, cur_edge, last_cell;
  logic [ADDR_W-1:0]  tap_addr;
  logic [TEMP_W-1:0]  wr_value;

  assign accept    = start && !busy;
  assign host_addr = ADDR_W'({cmd_i.row, cmd_i.col});
  assign cur_row   = cell_q[ADDR_W-1:IDX_W];
  assign cur_col   = cell_q[IDX_W-1:0];
  assign cur_src   = is_source(cur_row, cur_col);
  assign cur_edge  = (cur_row == '0) || (cur_row == '1) || (cur_col == '0) || (cur_col == '1);
  assign last_cell = (cell_q == LAST_CELL);

  // Neighbor addresses wrap on the edges; those taps go unused there
  always_comb begin
    case (tap_idx_q)
      TAP_W'(TAP_N):  tap_addr = cell_q - ADDR_W'(GRID_SIZE);
      TAP_W'(TAP_S):  tap_addr = cell_q + ADDR_W'(GRID_SIZE);
      TAP_W'(TAP_W_): tap_addr = cell_q - ADDR_W'(1);
      TAP_W'(TAP_E):  tap_addr = cell_q + ADDR_W'(1);
      default:        tap_addr = cell_q;
    endcase
  end

  always_comb begin
    if (cur_src) begin
      wr_value = src_cfg_q;
    end else if (cur_edge) begin
      wr_value = tap_q[TAP_C];
    end else begin
      wr_value = alu_res;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (last_cell) state_d = S_IDLE;
      S_IDLE: begin
        if (start && cmd_i.action == ACT_RUN) begin
          state_d = S_FORCE;
        end
      end
      S_FORCE: begin
        if (last_cell) begin
          state_d = (steps_cfg_q == '0) ? S_MM : S_RD;
        end
      end
      S_RD: begin
        if (tap_idx_q == TAP_W'(N_TAPS + 1)) begin
          state_d = (cur_src || cur_edge) ? S_WR : S_ALU;
        end
      end
      S_ALU: if (alu_done) state_d = S_WR;
      S_WR: begin
        if (last_cell && step_q + STEPS_W'(1) == steps_cfg_q) begin
          state_d = S_MM;
        end else begin
          state_d = S_RD;
        end
      end
      S_MM:   if (last_cell) state_d = S_MMT;
      S_MMT:  state_d = S_DONE;
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    mem_req   = '0;
    alu_start = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.wbank = 1'b0;
        mem_req.waddr = cell_q;
        mem_req.wdata = '0;
      end
      S_IDLE: begin
        mem_req.we    = accept && cmd_i.action == ACT_WRITE;
        mem_req.wbank = sel_q;
        mem_req.waddr = host_addr;
        mem_req.wdata = cmd_i.cell_value;
        mem_req.re    = accept && cmd_i.action == ACT_READ;
        mem_req.rbank = sel_q;
        mem_req.raddr = host_addr;
      end
      S_FORCE: begin
        mem_req.we    = cur_src;
        mem_req.wbank = sel_q;
        mem_req.waddr = cell_q;
        mem_req.wdata = src_cfg_q;
      end
      S_RD: begin
        mem_req.re    = tap_idx_q < TAP_W'(N_TAPS);
        mem_req.rbank = sel_q;
        mem_req.raddr = tap_addr;
        alu_start     = tap_idx_q == TAP_W'(N_TAPS + 1) && !cur_src && !cur_edge;
      end
      S_WR: begin
        mem_req.we    = 1'b1;
        mem_req.wbank = !sel_q;
        mem_req.waddr = cell_q;
        mem_req.wdata = wr_value;
      end
      S_MM: begin
        mem_req.re    = 1'b1;
        mem_req.rbank = sel_q;
        mem_req.raddr = cell_q;
      end
      default: begin
        mem_req = '0;
      end
    endcase
  end

  assign busy = (state_q != S_IDLE);

  hds_grid_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  hds_stencil_alu u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (alu_start),
    .alpha_i  (alpha_cfg_q),
    .tap_c_i  (tap_q[TAP_C]),
    .tap_n_i  (tap_q[TAP_N]),
    .tap_s_i  (tap_q[TAP_S]),
    .tap_w_i  (tap_q[TAP_W_]),
    .tap_e_i  (tap_q[TAP_E]),
    .done_o   (alu_done),
    .result_o (alu_res)
  );

  // Capture each tap in the cycle after its read
  always_ff @(posedge clk_i) begin
    if (state_q == S_RD && tap_idx_q != '0 && tap_idx_q <= TAP_W'(N_TAPS)) begin
      tap_q[tap_idx_q - TAP_W'(1)] <= rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      steps_cfg_q <= STEPS_RST;
      alpha_cfg_q <= ALPHA_RST;
      src_cfg_q   <= SRC_RST;
      sel_q       <= 1'b0;
      cell_q      <= '0;
      step_q      <= '0;
      tap_idx_q   <= '0;
      rd_pend_q   <= 1'b0;
      mm_vld_q    <= 1'b0;
      mm_first_q  <= 1'b0;
      min_q       <= '0;
      max_q       <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_STEPS: steps_cfg_q <= cfg_wdata_i[STEPS_W-1:0];
          CFG_ALPHA: alpha_cfg_q <= cfg_wdata_i[ALPHA_W-1:0];
          CFG_SRC:   src_cfg_q   <= cfg_wdata_i;
          default:   ;
        endcase
      end

      // Advance the cell sweep
      if (state_q == S_CLEAR || state_q == S_FORCE || state_q == S_MM ||
          state_q == S_WR) begin
        cell_q <= cell_q + ADDR_W'(1);
      end

      if (state_q == S_RD) begin
        tap_idx_q <= tap_idx_q + TAP_W'(1);
      end else begin
        tap_idx_q <= '0;
      end

      // End of a step: flip banks
      if (state_q == S_IDLE) begin
        step_q <= '0;
      end else if (state_q == S_WR && last_cell) begin
        sel_q  <= !sel_q;
        step_q <= step_q + STEPS_W'(1);
      end

      mm_vld_q   <= (state_q == S_MM);
      mm_first_q <= (state_q == S_MM) && (cell_q == '0);
      if (mm_vld_q) begin
        if (mm_first_q) begin
          min_q <= rdata;
          max_q <= rdata;
        end else begin
          if (rdata < min_q) min_q <= rdata;
          if (rdata > max_q) max_q <= rdata;
        end
      end

      rd_pend_q   <= accept && cmd_i.action == ACT_READ;
      res_valid_q <= rd_pend_q || (state_q == S_DONE);
      if (rd_pend_q) begin
        res_q <= '{kind: KIND_READ, out_value: rdata, min_value: '0, max_value: '0};
      end else if (state_q == S_DONE) begin
        res_q <= '{kind: KIND_RUN, out_value: '0, min_value: min_q, max_value: max_q};
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // Step sweeps write only the next bank
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR) |-> (mem_req.we && mem_req.wbank != sel_q))
    else $error("step write hit current bank");

  // Run results come only from the end of a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.kind == KIND_RUN) |-> $past(state_q == S_DONE))
    else $error("run result without finished run");

  // Stencil unit finishes only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_done |-> (state_q == S_ALU))
    else $error("stencil result outside wait state");

endmodule

/* design/hds_grid_mem.sv */
module hds_grid_mem (
  input  logic                        clk_i,
  input  hds_pkg::mem_req_t           req_i,
  output logic [hds_pkg::TEMP_W-1:0]  rdata_o
);
  import hds_pkg::*;

  localparam int DEPTH = 1 << ADDR_W;

  logic [TEMP_W-1:0] bank0 [DEPTH];
  logic [TEMP_W-1:0] bank1 [DEPTH];
  logic [TEMP_W-1:0] rd0_q;
  logic [TEMP_W-1:0] rd1_q;
  logic              rsel_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we && !req_i.wbank) begin
      bank0[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.we && req_i.wbank) begin
      bank1[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd0_q  <= bank0[req_i.raddr];
      rd1_q  <= bank1[req_i.raddr];
      rsel_q <= req_i.rbank;
    end
  end

  assign rdata_o = rsel_q ? rd1_q : rd0_q;

endmodule

/* design/hds_stencil_alu.sv */
module hds_stencil_alu (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [hds_pkg::ALPHA_W-1:0]  alpha_i,
  input  logic [hds_pkg::TEMP_W-1:0]   tap_c_i,
  input  logic [hds_pkg::TEMP_W-1:0]   tap_n_i,
  input  logic [hds_pkg::TEMP_W-1:0]   tap_s_i,
  input  logic [hds_pkg::TEMP_W-1:0]   tap_w_i,
  input  logic [hds_pkg::TEMP_W-1:0]   tap_e_i,
  output logic                         done_o,
  output logic [hds_pkg::TEMP_W-1:0]   result_o
);
  import hds_pkg::*;

  localparam int SUM_W  = TEMP_W + 2;
  localparam int LAP_W  = TEMP_W + 4;
  localparam int PROD_W = LAP_W + ALPHA_W + 1;
  localparam int SH_W   = PROD_W - FRAC_W;
  localparam int V_W    = SH_W + 2;

  logic [SUM_W-1:0]         sum;
  logic signed [LAP_W-1:0]  lap_d;
  logic signed [LAP_W-1:0]  lap_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [V_W-1:0]    v;
  logic [TEMP_W-1:0]        c1_q, c2_q, res_q;
  logic [2:0]               vld_q;

  assign sum   = SUM_W'(tap_n_i) + SUM_W'(tap_s_i) + SUM_W'(tap_w_i) + SUM_W'(tap_e_i);
  assign lap_d = $signed(LAP_W'(sum)) - $signed(LAP_W'({tap_c_i, 2'b00}));

  // Arithmetic shift of the product floors it toward minus infinity
  assign v = $signed(V_W'(c2_q)) + V_W'($signed(prod_q[PROD_W-1:FRAC_W]));

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      lap_q <= lap_d;
      c1_q  <= tap_c_i;
    end
    if (vld_q[0]) begin
      prod_q <= PROD_W'($signed({1'b0, alpha_i})) * PROD_W'(lap_q);
      c2_q   <= c1_q;
    end
    if (vld_q[1]) begin
      if (v < 0) begin
        res_q <= '0;
      end else if (v > $signed(V_W'(TEMP_MAX))) begin
        res_q <= TEMP_MAX;
      end else begin
        res_q <= v[TEMP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], start_i};
    end
  end

  assign done_o   = vld_q[2];
  assign result_o = res_q;

endmodule
